@@ rtl/core/ipa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_pkg
// Shared types for the id pool allocator: commands, status codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ipa_pkg;

  localparam int POOL_SIZE_W = 11;
  localparam int ID_FIELD_W  = 10;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_DOUBLE    = 3'd2,
    ST_NOT_ALLOC = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_ALLOC_CHK
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic pop;
    logic finish;
    logic chk;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_release;
    logic empty;
    logic out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/ipa_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_req_if
// Request channel: allocate or release command with the released id.
// ----------------------------------------------------------------------------
interface ipa_req_if import ipa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cmd_e                  command;
  logic [ID_FIELD_W-1:0] release_id;

  modport source (output valid, output command, output release_id, input ready);
  modport sink   (input valid, input command, input release_id, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ipa_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_rsp_if
// Response channel: granted id and status of one request.
// ----------------------------------------------------------------------------
interface ipa_rsp_if import ipa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ID_FIELD_W-1:0] granted_id;
  status_e               status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ipa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ipa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ipa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_ctrl
// Controller: clearing sweep, request accept, stack pop and finish sequencing.
// ----------------------------------------------------------------------------
module ipa_ctrl import ipa_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire ctl_sts_t sts_i,
  output ctl_cmd_t      ctl_o
);

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE) && !cfg_we_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_ready_o && req_valid_i) state_d = S_LOOK;
      end
      S_LOOK: begin
        if (sts_i.is_release || sts_i.empty) begin
          if (sts_i.out_free) state_d = S_IDLE;
        end else begin
          state_d = S_ALLOC_CHK;
        end
      end
      S_ALLOC_CHK: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
    if (cfg_we_i) state_d = S_CLEAR;
  end

  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      S_CLEAR: begin
        ctl_o.clear_step = 1'b1;
      end
      S_IDLE: begin
        ctl_o.accept = req_ready_o && req_valid_i;
      end
      S_LOOK: begin
        if (sts_i.is_release || sts_i.empty) begin
          ctl_o.finish = sts_i.out_free;
        end else begin
          ctl_o.pop = 1'b1;
        end
      end
      S_ALLOC_CHK: begin
        ctl_o.finish = sts_i.out_free;
        ctl_o.chk    = 1'b1;
      end
      default: ctl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_chk_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ALLOC_CHK |-> $past(state_q) == S_LOOK || $past(state_q) == S_ALLOC_CHK)
    else $error("check state entered without a lookup");

endmodule
`default_nettype wire

@@ rtl/core/ipa_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_dpath
// Datapath: free stack and mark RAMs, top index, pool size, result register.
// ----------------------------------------------------------------------------
module ipa_dpath import ipa_pkg::*; #(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [POOL_SIZE_W-1:0] cfg_wdata_i,
  input  wire cmd_e                   req_command_i,
  input  wire logic [ID_FIELD_W-1:0]  req_release_id_i,
  input  wire logic                   rsp_ready_i,
  input  wire ctl_cmd_t               ctl_i,
  output ctl_sts_t                    sts_o,
  output logic                        rsp_valid_o,
  output logic [ID_FIELD_W-1:0]       rsp_granted_id_o,
  output status_e                     rsp_status_o
);

  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int TOP_W = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W = (TOP_W > POOL_SIZE_W) ? TOP_W : POOL_SIZE_W;

  logic [TOP_W-1:0]      top_q, top_d;
  logic [CMP_W-1:0]      pool_q, pool_d;
  logic [IDX_W-1:0]      sw_q, sw_d;
  cmd_e                  cmd_q;
  logic [ID_FIELD_W-1:0] rid_q;
  logic [IDX_W-1:0]      v_q;
  logic                  out_valid_q;
  logic [ID_FIELD_W-1:0] granted_q;
  status_e               status_q;

  logic [IDX_W-1:0]      stk_rdata, stk_waddr, stk_wdata;
  logic                  stk_we, stk_re;
  logic [0:0]            mk_rdata, mk_wdata;
  logic [IDX_W-1:0]      mk_waddr, mk_raddr;
  logic                  mk_we, mk_re;

  logic [CMP_W-1:0]      cfg_sat;
  logic                  rid_oor, v_oor;
  logic [IDX_W-1:0]      rid_idx, push_idx;
  status_e               res_status;
  logic [ID_FIELD_W-1:0] res_granted;

  assign cfg_sat  = (CMP_W'(cfg_wdata_i) > CMP_W'(POOL_DEPTH)) ? CMP_W'(POOL_DEPTH)
                                                               : CMP_W'(cfg_wdata_i);
  assign rid_oor  = CMP_W'(rid_q) >= pool_q;
  assign v_oor    = CMP_W'(v_q) >= CMP_W'(POOL_DEPTH);
  assign rid_idx  = IDX_W'(rid_q);
  assign push_idx = IDX_W'(top_q - 1'b1);

  assign sts_o.clear_last = sw_q == IDX_W'(POOL_DEPTH - 1);
  assign sts_o.is_release = cmd_q == CMD_RELEASE;
  assign sts_o.empty      = CMP_W'(top_q) >= pool_q;
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  always_comb begin
    top_d       = top_q;
    pool_d      = pool_q;
    sw_d        = sw_q;
    stk_we      = 1'b0;
    stk_waddr   = sw_q;
    stk_wdata   = sw_q;
    mk_we       = 1'b0;
    mk_waddr    = sw_q;
    mk_wdata    = 1'b0;
    stk_re      = ctl_i.accept;
    mk_re       = ctl_i.accept || ctl_i.pop;
    mk_raddr    = ctl_i.pop ? stk_rdata : IDX_W'(req_release_id_i);
    res_status  = ST_OK;
    res_granted = '0;

    if (ctl_i.clear_step) begin
      stk_we = 1'b1;
      mk_we  = 1'b1;
      sw_d   = sw_q + 1'b1;
    end

    if (ctl_i.pop) begin
      top_d = top_q + 1'b1;
    end

    if (ctl_i.finish) begin
      if (ctl_i.chk) begin
        if (v_oor || mk_rdata[0]) begin
          res_status = ST_DOUBLE;
        end else begin
          mk_we       = 1'b1;
          mk_waddr    = v_q;
          mk_wdata    = 1'b1;
          res_granted = ID_FIELD_W'(v_q);
        end
      end else if (cmd_q == CMD_ALLOC) begin
        res_status = ST_EMPTY;
      end else if (rid_oor) begin
        res_status = ST_RANGE;
      end else if (!mk_rdata[0]) begin
        res_status = ST_NOT_ALLOC;
      end else begin
        mk_we    = 1'b1;
        mk_waddr = rid_idx;
        mk_wdata = 1'b0;
        if (top_q != '0) begin
          top_d     = top_q - 1'b1;
          stk_we    = 1'b1;
          stk_waddr = push_idx;
          stk_wdata = rid_idx;
        end
      end
    end

    if (cfg_we_i) begin
      pool_d = cfg_sat;
      top_d  = '0;
      sw_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      pool_q      <= CMP_W'(POOL_DEPTH);
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      top_q       <= top_d;
      pool_q      <= pool_d;
      sw_q        <= sw_d;
      out_valid_q <= ctl_i.finish ? 1'b1 : (rsp_ready_i ? 1'b0 : out_valid_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q <= req_command_i;
      rid_q <= req_release_id_i;
    end
    if (ctl_i.pop) begin
      v_q <= stk_rdata;
    end
    if (ctl_i.finish) begin
      granted_q <= res_granted;
      status_q  <= res_status;
    end
  end

  ipa_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (IDX_W'(top_q)),
    .rdata_o (stk_rdata)
  );

  ipa_ram #(.WIDTH(1), .DEPTH(POOL_DEPTH)) u_marks (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (mk_waddr),
    .wdata_i (mk_wdata),
    .re_i    (mk_re),
    .raddr_i (mk_raddr),
    .rdata_o (mk_rdata)
  );

  assign rsp_valid_o      = out_valid_q;
  assign rsp_granted_id_o = granted_q;
  assign rsp_status_o     = status_q;

  a_top_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(top_q) <= pool_q)
    else $error("top index beyond pool size");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.finish |-> !out_valid_q || rsp_ready_i)
    else $error("result overwrites pending transaction");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |-> granted_q == '0)
    else $error("nonzero id on failed request");

  a_one_ram_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear_step |-> !ctl_i.accept && !ctl_i.pop && !ctl_i.finish)
    else $error("request work during clearing sweep");

endmodule
`default_nettype wire

@@ rtl/core/id_pool_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id_pool_allocator
// Id allocator built on a stack of free ids and one allocated mark per id.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   command, release_id
//   rsp_o    out  valid/ready   granted_id, status
//   cfg      in   cfg_we_i      cfg_wdata_i (pool_size)
//
// release and empty allocate finish in S_LOOK; allocate goes on to S_ALLOC_CHK
// (stack read, then dependent mark read in registered-read RAMs, then mark update).
// after reset and after each pool_size write a clearing pass runs over all
// POOL_DEPTH entries, restoring identity stack order and clearing marks;
// no request is accepted during it.
// a stalled response holds the finishing request in its last state.
// ----------------------------------------------------------------------------
module id_pool_allocator import ipa_pkg::*; #(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [POOL_SIZE_W-1:0] cfg_wdata_i,
  ipa_req_if.sink                     req_i,
  ipa_rsp_if.source                   rsp_o
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  ipa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  ipa_dpath #(.POOL_DEPTH(POOL_DEPTH)) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_command_i    (req_i.command),
    .req_release_id_i (req_i.release_id),
    .rsp_ready_i      (rsp_o.ready),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_granted_id_o (rsp_o.granted_id),
    .rsp_status_o     (rsp_o.status)
  );

endmodule
`default_nettype wire

@@ tb/sv/id_pool_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_pool_allocator_tb
// Self-checking bench for the id pool allocator. A queue of allocate and
// release requests feeds a clocked driver, and a clocked monitor checks each
// response against a shadow free-id stack and mark table. The bench writes
// pool_size between phases with the block idle, with random gaps on both
// channels, one long response stall and sender pauses until drained.
// ----------------------------------------------------------------------------
module id_pool_allocator_tb;
  import ipa_pkg::*;

  localparam int POOL_DEPTH    = 1024;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 75;

  typedef struct {
    cmd_e                  command;
    logic [ID_FIELD_W-1:0] release_id;
    bit                    drain;
  } id_request_t;

  typedef struct {
    logic [ID_FIELD_W-1:0] granted_id;
    status_e               status;
  } id_reply_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [POOL_SIZE_W-1:0] cfg_wdata_i;

  ipa_req_if req_if();
  ipa_rsp_if rsp_if();

  id_pool_allocator #(
    .POOL_DEPTH(POOL_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  // shadow pool state
  logic [ID_FIELD_W-1:0]  free_ids [POOL_DEPTH];
  bit                     id_taken [POOL_DEPTH];
  logic [POOL_SIZE_W-1:0] free_top;
  logic [POOL_SIZE_W-1:0] pool_limit;

  id_request_t request_q[$];
  id_reply_t   reply_q[$];

  int error_count = 0;
  int cycle_count = 0;
  int hold_asks   = 0;
  int hold_seen   = 0;
  int send_wait   = 0;
  int recv_wait   = 0;
  bit send_calm   = 1'b0;
  bit recv_calm   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int draw_gap(input bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic void reset_pool(input logic [POOL_SIZE_W-1:0] size);
    for (int i = 0; i < POOL_DEPTH; i++) begin
      free_ids[i] = ID_FIELD_W'(i);
      id_taken[i] = 1'b0;
    end
    free_top   = '0;
    pool_limit = (size > POOL_DEPTH) ? POOL_SIZE_W'(POOL_DEPTH) : size;
  endfunction

  function automatic void predict_grant(input cmd_e command,
                                        input logic [ID_FIELD_W-1:0] rid);
    id_reply_t             reply;
    logic [ID_FIELD_W-1:0] popped;
    reply.granted_id = '0;
    reply.status     = ST_OK;
    if (command == CMD_ALLOC) begin
      if (free_top >= pool_limit) begin
        reply.status = ST_EMPTY;
      end else begin
        popped   = free_ids[free_top];
        free_top = free_top + 1'b1;
        if (id_taken[popped]) begin
          reply.status = ST_DOUBLE;
        end else begin
          id_taken[popped] = 1'b1;
          reply.granted_id = popped;
        end
      end
    end else if ({1'b0, rid} >= pool_limit) begin
      reply.status = ST_RANGE;
    end else if (!id_taken[rid]) begin
      reply.status = ST_NOT_ALLOC;
    end else begin
      id_taken[rid] = 1'b0;
      if (free_top != 0) begin
        free_top           = free_top - 1'b1;
        free_ids[free_top] = rid;
      end
    end
    reply_q.push_back(reply);
  endfunction

  task automatic queue_request(input cmd_e command, input int rid, input bit drain = 1'b0);
    id_request_t item;
    item.command    = command;
    item.release_id = ID_FIELD_W'(rid);
    item.drain      = drain;
    request_q.push_back(item);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    #1;
    while (request_q.size() != 0 || req_if.valid || reply_q.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pool_size(input int size);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= POOL_SIZE_W'(size);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reset_pool(POOL_SIZE_W'(size));
  endtask

  task automatic queue_random_phase(input int count, input bit with_drain);
    int  handed;
    int  pick;
    int  span;
    bit  drain;
    handed = 0;
    for (int n = 0; n < count; n++) begin
      pick  = $urandom_range(0, 99);
      span  = (handed < pool_limit) ? handed : int'(pool_limit);
      drain = (with_drain && n == count / 2) || $urandom_range(0, 49) == 0;
      if (pick < 50) begin
        queue_request(CMD_ALLOC, $urandom_range(0, POOL_DEPTH - 1), drain);
        handed++;
      end else if (pick < 85 && span > 0) begin
        queue_request(CMD_RELEASE, $urandom_range(0, span - 1), drain);
      end else if (pick < 95 || pool_limit >= POOL_DEPTH) begin
        queue_request(CMD_RELEASE, $urandom_range(0, POOL_DEPTH - 1), drain);
      end else begin
        queue_request(CMD_RELEASE, $urandom_range(pool_limit, POOL_DEPTH - 1), drain);
      end
    end
  endtask

  // request driver, predicts on each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    id_request_t next_item;
    bit          offer;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_wait = 0;
    end else begin
      offer = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        predict_grant(req_if.command, req_if.release_id);
        offer = 1'b0;
        if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
        send_wait = draw_gap(send_calm);
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (request_q.size() != 0 &&
                     (!request_q[0].drain || reply_q.size() == 0)) begin
          next_item = request_q.pop_front();
          req_if.command    <= next_item.command;
          req_if.release_id <= next_item.release_id;
          offer = 1'b1;
        end
      end
      req_if.valid <= offer;
    end
  end

  // response monitor and ready generation
  always @(posedge clk_i or negedge rst_ni) begin : reply_monitor
    id_reply_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected transaction, granted_id %0d status %0d",
                   $time, rsp_if.granted_id, rsp_if.status);
          error_count++;
        end else begin
          want = reply_q.pop_front();
          if (rsp_if.granted_id !== want.granted_id) begin
            $display("%0t: granted_id mismatch, expected %0d actual %0d",
                     $time, want.granted_id, rsp_if.granted_id);
            error_count++;
          end
          if (rsp_if.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, rsp_if.status);
            error_count++;
          end
        end
        if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
        recv_wait = draw_gap(recv_calm);
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        recv_wait = LONG_HOLD;
      end
      if (recv_wait > 0) begin
        rsp_if.ready <= 1'b0;
        recv_wait--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int size;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.command    = CMD_ALLOC;
    req_if.release_id = '0;
    rsp_if.ready      = 1'b0;
    reset_pool(POOL_SIZE_W'(POOL_DEPTH));

    // full pool after reset
    queue_request(CMD_RELEASE, POOL_DEPTH - 1);
    queue_request(CMD_RELEASE, 0);
    queue_request(CMD_ALLOC, POOL_DEPTH - 1);
    queue_request(CMD_ALLOC, 0);
    queue_request(CMD_RELEASE, 0);
    queue_request(CMD_ALLOC, 0);
    queue_request(CMD_RELEASE, 1);
    queue_request(CMD_RELEASE, 0, 1'b1);
    queue_request(CMD_ALLOC, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero-size pool
    write_pool_size(0);
    queue_request(CMD_ALLOC, 0);
    queue_request(CMD_RELEASE, 0);
    queue_request(CMD_RELEASE, POOL_DEPTH - 1);

    // single id, exhaustion and release of unallocated id
    write_pool_size(1);
    queue_request(CMD_ALLOC, 0);
    queue_request(CMD_ALLOC, 0);
    queue_request(CMD_RELEASE, 1);
    queue_request(CMD_RELEASE, 0);
    queue_request(CMD_RELEASE, 0);
    queue_request(CMD_ALLOC, 0);

    // oversized write saturates to the full depth
    write_pool_size(2047);
    queue_request(CMD_RELEASE, POOL_DEPTH - 1);
    queue_request(CMD_ALLOC, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          size = POOL_DEPTH;
        end
        1: begin
          size = 2047;
        end
        2: begin
          size = 1;
        end
        default: begin
          size = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047)
                                             : $urandom_range(2, 24);
        end
      endcase
      write_pool_size(size);
      queue_random_phase(PHASE_ITEMS, p == 3);
      if (p == 4) hold_asks++;
    end

    wait_idle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
